// ===== rtl/core/brtd_pkg.sv =====
// Shared types, constants and helper functions of the bitmap row text decoder.
package brtd_pkg;

   localparam int MAX_DIM = 1024;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);

   // Configuration register indexes
   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_WIDTH     = 3'd1;
   localparam logic [2:0] CSR_HEIGHT    = 3'd2;
   localparam logic [2:0] CSR_DEPTH     = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD = 3'd4;

   // Decoding modes
   localparam logic [1:0] MODE_BIT  = 2'd0;
   localparam logic [1:0] MODE_HEX  = 2'd1;
   localparam logic [1:0] MODE_RUNS = 2'd2;

   // Command kinds
   localparam logic [1:0] KIND_GROUP  = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_REPEAT = 2'd2;

   // Character codes
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_BANG    = 8'd33;
   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_N = 8'd110;
   localparam logic [7:0] CH_BAR     = 8'd124;
   localparam logic [7:0] ON_RUN_BASE  = 8'd108;
   localparam logic [7:0] OFF_RUN_BASE = 8'd95;

   localparam logic [7:0] RESET_MODE      = 8'd2;
   localparam logic [6:0] RESET_THRESHOLD = 7'd49;

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_AFTER_CR,
      PH_COUNT,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] depth;
      logic [6:0]       on_threshold;
   } cfg_type;

   typedef struct packed {
      phase_type        phase;
      logic [DIM_W-1:0] column_pos;
      logic [DIM_W-1:0] row_pos;
      logic [DIM_W-1:0] plane_pos;
      logic [DIM_W-1:0] count_acc;
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  plane;
      logic [9:0]  row;
      logic [9:0]  column;
      logic [5:0]  pattern;
      logic [2:0]  pattern_bits;
      logic [6:0]  run_length;
      logic [10:0] repeat_count;
   } cmd_type;

   // Zero acts as one, anything above the largest dimension is clamped.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [10:0] v);
      logic [DIM_W-1:0] r;
      if (v == 11'd0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // Non-hex characters count as digit zero.
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] r;
      if (c >= 8'd48 && c <= 8'd57) begin
         r = 4'(c - 8'd48);
      end else if (c >= 8'd97 && c <= 8'd102) begin
         r = 4'(c - 8'd87);
      end else if (c >= 8'd65 && c <= 8'd70) begin
         r = 4'(c - 8'd55);
      end else begin
         r = 4'd0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/brtd_cfg.sv =====
// Configuration registers of the bitmap row text decoder and their effective values.
module brtd_cfg (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [10:0]        csr_data,
   output brtd_pkg::cfg_type  cfg
);

   logic [1:0]  mode_ff,   mode_in;
   logic [10:0] width_ff,  width_in;
   logic [10:0] height_ff, height_in;
   logic [10:0] depth_ff,  depth_in;
   logic [6:0]  thr_ff,    thr_in;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      thr_in    = thr_ff;
      if (csr_write) begin
         case (csr_index)
            brtd_pkg::CSR_MODE:      mode_in   = csr_data[1:0];
            brtd_pkg::CSR_WIDTH:     width_in  = csr_data;
            brtd_pkg::CSR_HEIGHT:    height_in = csr_data;
            brtd_pkg::CSR_DEPTH:     depth_in  = csr_data;
            brtd_pkg::CSR_THRESHOLD: thr_in    = csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= brtd_pkg::RESET_MODE[1:0];
         width_ff  <= 11'(brtd_pkg::MAX_DIM);
         height_ff <= 11'(brtd_pkg::MAX_DIM);
         depth_ff  <= 11'(brtd_pkg::MAX_DIM);
         thr_ff    <= brtd_pkg::RESET_THRESHOLD;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         thr_ff    <= thr_in;
      end
   end

   // Mode three behaves as one character per pixel, which the decoder treats as default.
   always_comb begin
      cfg.mode         = mode_ff;
      cfg.width        = brtd_pkg::eff_dim(width_ff);
      cfg.height       = brtd_pkg::eff_dim(height_ff);
      cfg.depth        = brtd_pkg::eff_dim(depth_ff);
      cfg.on_threshold = thr_ff;
   end

endmodule

// ===== rtl/core/brtd_step.sv =====
// Decode of one body character: next position state and the write command it causes.
module brtd_step (
   input  brtd_pkg::state_type st,
   input  logic [7:0]          char_code,
   input  brtd_pkg::cfg_type   cfg,
   output brtd_pkg::state_type nx,
   output logic                emit,
   output brtd_pkg::cmd_type   cmd
);

   localparam int DW = brtd_pkg::DIM_W;

   logic          is_ctrl, is_cr, is_lf, is_digit;
   logic          done_in, swallow_lf, in_count;
   logic          plane_end, last_plane, plane_sep, body;
   logic [DW-1:0] plane_inc, row_b, col_b, plane_b;
   logic          mode_hex, mode_runs;
   logic          is_group, is_marker, is_on_run;
   logic [2:0]    nbits, gbits;
   logic [5:0]    val6;
   logic [7:0]    run_k8;
   logic [4:0]    run_k;
   logic [6:0]    run_len, adv, run_out;
   logic [DW:0]   col_sum;
   logic [DW-1:0] col_adv, room;
   logic          col_ok;
   logic [14:0]   acc10;
   logic [DW-1:0] acc_sat, rows_left, n_req, n_clip;
   logic          row_ok, rep_emit;

   assign is_cr    = (char_code == brtd_pkg::CH_CR);
   assign is_lf    = (char_code == brtd_pkg::CH_LF);
   assign is_ctrl  = (char_code < brtd_pkg::CH_SPACE) || char_code[7];
   assign is_digit = (char_code >= brtd_pkg::CH_ZERO) && (char_code <= brtd_pkg::CH_NINE);

   assign done_in    = (st.phase == brtd_pkg::PH_DONE) || (st.plane_pos >= cfg.depth);
   assign swallow_lf = (st.phase == brtd_pkg::PH_AFTER_CR) && is_lf;
   assign in_count   = (st.phase == brtd_pkg::PH_COUNT);

   // A plane whose rows are all done is closed by whatever character comes next.
   assign plane_end  = !done_in && !swallow_lf && !in_count && (st.row_pos >= cfg.height);
   assign plane_inc  = st.plane_pos + DW'(1);
   assign last_plane = plane_end && (plane_inc >= cfg.depth);
   assign plane_sep  = plane_end && !last_plane && (is_cr || is_lf);
   assign body       = !done_in && !swallow_lf && !in_count && !last_plane && !plane_sep;

   assign row_b   = plane_end ? '0 : st.row_pos;
   assign col_b   = plane_end ? '0 : st.column_pos;
   assign plane_b = plane_end ? plane_inc : st.plane_pos;

   assign mode_hex  = (cfg.mode == brtd_pkg::MODE_HEX);
   assign mode_runs = (cfg.mode == brtd_pkg::MODE_RUNS);

   assign is_group  = body && !is_ctrl &&
                      (!mode_runs || (char_code < brtd_pkg::CH_LOWER_A));
   assign is_marker = body && !is_ctrl && mode_runs && (char_code == brtd_pkg::CH_BAR);
   assign is_on_run = body && !is_ctrl && mode_runs &&
                      (char_code >= brtd_pkg::CH_LOWER_N) && (char_code != brtd_pkg::CH_BAR);

   always_comb begin
      if (mode_hex) begin
         nbits = 3'd4;
         val6  = {2'b00, brtd_pkg::hex_val(char_code)};
      end else if (mode_runs) begin
         nbits = 3'd6;
         val6  = 6'(char_code - brtd_pkg::CH_BANG);
      end else begin
         nbits = 3'd1;
         val6  = {5'd0, (char_code >= {1'b0, cfg.on_threshold})};
      end
   end

   // Runs cover two or more six-pixel groups; the length is k times six.
   assign run_k8  = (char_code >= brtd_pkg::CH_LOWER_N) ? (char_code - brtd_pkg::ON_RUN_BASE)
                                                        : (char_code - brtd_pkg::OFF_RUN_BASE);
   assign run_k   = run_k8[4:0];
   assign run_len = 7'({run_k, 2'b00}) + 7'({run_k, 1'b0});
   assign adv     = is_group ? 7'(nbits) : run_len;

   assign col_sum = {1'b0, col_b} + (DW + 1)'(adv);
   assign col_adv = (col_sum > (DW + 1)'(brtd_pkg::MAX_DIM)) ? DW'(brtd_pkg::MAX_DIM)
                                                              : col_sum[DW-1:0];
   assign col_ok  = (col_b < cfg.width);
   assign room    = cfg.width - col_b;
   assign gbits   = (room < DW'(nbits)) ? room[2:0] : nbits;
   assign run_out = (room < DW'(run_len)) ? room[6:0] : run_len;

   assign acc10   = 15'({st.count_acc, 3'b000}) + 15'({st.count_acc, 1'b0}) +
                    15'(char_code[3:0]);
   assign acc_sat = (acc10 > 15'(cfg.height)) ? cfg.height : acc10[DW-1:0];

   assign row_ok    = (st.row_pos < cfg.height);
   assign rows_left = cfg.height - st.row_pos;
   assign n_req     = (st.count_acc == '0) ? DW'(1) : st.count_acc;
   assign n_clip    = (n_req > rows_left) ? rows_left : n_req;
   assign rep_emit  = !done_in && in_count && !is_digit && row_ok && (st.row_pos != '0);

   // Next state
   always_comb begin
      nx = st;
      if (done_in) begin
         nx.phase = brtd_pkg::PH_DONE;
      end else if (in_count) begin
         if (is_digit) begin
            nx.count_acc = acc_sat;
         end else begin
            nx.phase      = is_cr ? brtd_pkg::PH_AFTER_CR : brtd_pkg::PH_NORMAL;
            nx.column_pos = '0;
            if (row_ok) begin
               nx.row_pos = st.row_pos + n_clip;
            end
         end
      end else if (swallow_lf) begin
         nx.phase = brtd_pkg::PH_NORMAL;
      end else begin
         nx.phase      = brtd_pkg::PH_NORMAL;
         nx.plane_pos  = plane_b;
         nx.row_pos    = row_b;
         nx.column_pos = col_b;
         if (last_plane) begin
            nx.phase = brtd_pkg::PH_DONE;
         end else if (plane_sep) begin
            nx.phase = is_cr ? brtd_pkg::PH_AFTER_CR : brtd_pkg::PH_NORMAL;
         end else if (is_ctrl) begin
            nx.row_pos    = row_b + DW'(1);
            nx.column_pos = '0;
            nx.phase      = is_cr ? brtd_pkg::PH_AFTER_CR : brtd_pkg::PH_NORMAL;
         end else if (is_marker) begin
            nx.phase     = brtd_pkg::PH_COUNT;
            nx.count_acc = '0;
         end else begin
            nx.column_pos = col_adv;
         end
      end
   end

   // Command
   always_comb begin
      emit = 1'b0;
      cmd  = '0;
      cmd.plane = plane_b[9:0];
      cmd.row   = row_b[9:0];
      if (rep_emit) begin
         emit             = 1'b1;
         cmd.kind         = brtd_pkg::KIND_REPEAT;
         cmd.row          = st.row_pos[9:0];
         cmd.repeat_count = n_clip;
      end else if (is_group && col_ok) begin
         emit             = 1'b1;
         cmd.kind         = brtd_pkg::KIND_GROUP;
         cmd.column       = col_b[9:0];
         cmd.pattern      = val6 >> (nbits - gbits);
         cmd.pattern_bits = gbits;
      end else if (is_on_run && col_ok) begin
         emit           = 1'b1;
         cmd.kind       = brtd_pkg::KIND_RUN;
         cmd.column     = col_b[9:0];
         cmd.run_length = run_out;
      end
   end

endmodule

// ===== rtl/core/bitmap_row_text_decoder.sv =====
// Top level of the bitmap row text decoder: input register, position state and result register.
//
//  Port group   Direction  Handshake          Carries
//  req_         in         req_valid/stall    one body character per transfer
//  rsp_         out        rsp_valid/stall    one pixel write command per transfer
//  csr_         in         csr_write          mode, width, height, depth, on threshold
//
// A character is decoded while it sits in the input register; its command then goes to the
// result register. The position state is updated once per character.
// One character is taken every cycle unless a held result is stalled.
// Reset is synchronous, clears the position state and both valid flags, and restores the
// configuration registers to their reset values.
// A stalled result holds the input register; only an empty one still takes a character.
module bitmap_row_text_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_plane,
   output logic [9:0]  rsp_row,
   output logic [9:0]  rsp_column,
   output logic [5:0]  rsp_pattern,
   output logic [2:0]  rsp_pattern_bits,
   output logic [6:0]  rsp_run_length,
   output logic [10:0] rsp_repeat_count,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data
);

   brtd_pkg::cfg_type   cfg;
   brtd_pkg::state_type state_ff, state_in;
   brtd_pkg::cmd_type   cmd_ff, cmd_in;
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                fire, emit;

   brtd_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   brtd_step u_step (
      .st        (state_ff),
      .char_code (in_char_ff),
      .cfg       (cfg),
      .nx        (state_in),
      .emit      (emit),
      .cmd       (cmd_in)
   );

   // The held character is decoded once the result register is free or being emptied.
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: brtd_pkg::PH_NORMAL, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
      end
      if (fire && emit) begin
         cmd_ff <= cmd_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = cmd_ff.kind;
   assign rsp_plane        = cmd_ff.plane;
   assign rsp_row          = cmd_ff.row;
   assign rsp_column       = cmd_ff.column;
   assign rsp_pattern      = cmd_ff.pattern;
   assign rsp_pattern_bits = cmd_ff.pattern_bits;
   assign rsp_run_length   = cmd_ff.run_length;
   assign rsp_repeat_count = cmd_ff.repeat_count;

   // A pixel group never reaches past the row width.
   a_group_in_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cmd_ff.kind == brtd_pkg::KIND_GROUP) |->
      (cmd_ff.pattern_bits != 3'd0 &&
       (11'(cmd_ff.column) + 11'(cmd_ff.pattern_bits)) <= cfg.width))
      else $error("pixel group extends past the row width");

   // A repeat always copies at least one row and never targets the first row.
   a_repeat_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cmd_ff.kind == brtd_pkg::KIND_REPEAT) |->
      (cmd_ff.repeat_count != 11'd0 && cmd_ff.row != 10'd0))
      else $error("repeat command with no rows or on the first row");

   // Once the volume is complete the decoder stays finished.
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == brtd_pkg::PH_DONE) |=> (state_ff.phase == brtd_pkg::PH_DONE))
      else $error("decoder left the finished phase");

   // The column position saturates at the largest dimension.
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      32'(state_ff.column_pos) <= brtd_pkg::MAX_DIM)
      else $error("column position beyond the largest dimension");

endmodule

// ===== sim/bitmap_row_text_decoder_checker.sv =====
// Checker for the bitmap row text decoder: predicts each write command and compares it.
module bitmap_row_text_decoder_checker
   import brtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [9:0]  rsp_plane,
   input  logic [9:0]  rsp_row,
   input  logic [9:0]  rsp_column,
   input  logic [5:0]  rsp_pattern,
   input  logic [2:0]  rsp_pattern_bits,
   input  logic [6:0]  rsp_run_length,
   input  logic [10:0] rsp_repeat_count,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data,
   output int          failures,
   output int          outstanding,
   output int          plane_now
);

   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam int MAX_REPORTS = 10;

   logic [1:0] cfg_mode;
   int         cfg_width;
   int         cfg_height;
   int         cfg_depth;
   int         cfg_threshold;

   phase_type  ph;
   int         col_pos;
   int         row_pos;
   int         plane_pos;
   int         count_acc;

   cmd_type    predicted_cmds[$];

   assign plane_now = plane_pos;

   function automatic int dim_of(input int v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int hex_nibble(input int code);
      if (code >= CH_ZERO && code <= CH_NINE) return code - CH_ZERO;
      if (code >= CH_LOWER_A && code <= CH_LOWER_A + 5) return code - CH_LOWER_A + 10;
      if (code >= CH_UPPER_A && code <= CH_UPPER_A + 5) return code - CH_UPPER_A + 10;
      return 0;
   endfunction

   function automatic void move_column(input int n);
      col_pos = (col_pos + n > MAX_DIM) ? MAX_DIM : col_pos + n;
   endfunction

   function automatic cmd_type build_cmd(input logic [1:0] kind, input int row, input int col,
                                         input int pat, input int bits, input int run,
                                         input int rep);
      cmd_type cmd;
      cmd.kind         = kind;
      cmd.plane        = 10'(plane_pos);
      cmd.row          = 10'(row);
      cmd.column       = 10'(col);
      cmd.pattern      = 6'(pat);
      cmd.pattern_bits = 3'(bits);
      cmd.run_length   = 7'(run);
      cmd.repeat_count = 11'(rep);
      return cmd;
   endfunction

   // Pixels that fall at or past the width are cut off the right-hand end of the group.
   function automatic bit place_group(input int val, input int nbits, input int w,
                                      output cmd_type cmd);
      int start;
      int bits;
      start = col_pos;
      move_column(nbits);
      if (start >= w) return 0;
      bits = (w - start < nbits) ? w - start : nbits;
      cmd = build_cmd(KIND_GROUP, row_pos, start, val >> (nbits - bits), bits, 0, 0);
      return 1;
   endfunction

   function automatic bit decode_char(input logic [7:0] c, output cmd_type cmd);
      int code;
      int w;
      int h;
      int d;
      int n;
      int first;
      int len;
      int start;
      bit line_end;
      code = c;
      w = dim_of(cfg_width);
      h = dim_of(cfg_height);
      d = dim_of(cfg_depth);
      line_end = (code < CH_SPACE) || c[7];
      cmd = '0;

      if (ph == PH_DONE || plane_pos >= d) begin
         ph = PH_DONE;
         return 0;
      end

      if (ph == PH_AFTER_CR) begin
         ph = PH_NORMAL;
         if (c == CH_LF) return 0;
      end

      if (ph == PH_COUNT) begin
         if (code >= CH_ZERO && code <= CH_NINE) begin
            count_acc = count_acc * 10 + (code - CH_ZERO);
            if (count_acc > h) count_acc = h;
            return 0;
         end
         // The byte that ends the count is swallowed.
         ph = (c == CH_CR) ? PH_AFTER_CR : PH_NORMAL;
         col_pos = 0;
         if (row_pos >= h) return 0;
         n = (count_acc == 0) ? 1 : count_acc;
         if (n > h - row_pos) n = h - row_pos;
         first = row_pos;
         row_pos += n;
         if (first == 0) return 0;
         cmd = build_cmd(KIND_REPEAT, first, 0, 0, 0, 0, n);
         return 1;
      end

      // A full plane is closed by whatever byte comes next.
      if (row_pos >= h) begin
         plane_pos++;
         row_pos = 0;
         col_pos = 0;
         if (plane_pos >= d) begin
            ph = PH_DONE;
            return 0;
         end
         if (c == CH_CR) begin
            ph = PH_AFTER_CR;
            return 0;
         end
         if (c == CH_LF) return 0;
      end

      if (line_end) begin
         row_pos++;
         col_pos = 0;
         if (c == CH_CR) ph = PH_AFTER_CR;
         return 0;
      end

      if (cfg_mode == MODE_HEX) return place_group(hex_nibble(code), 4, w, cmd);
      if (cfg_mode != MODE_RUNS) return place_group((code >= cfg_threshold) ? 1 : 0, 1, w, cmd);

      if (code < CH_LOWER_A) return place_group((code - 33) & 63, 6, w, cmd);
      if (c == CH_BAR) begin
         ph = PH_COUNT;
         count_acc = 0;
         return 0;
      end
      if (code >= CH_LOWER_N) begin
         len = (code - CH_LOWER_N + 2) * 6;
         start = col_pos;
         move_column(len);
         if (start >= w) return 0;
         if (len > w - start) len = w - start;
         cmd = build_cmd(KIND_RUN, row_pos, start, 0, 0, len, 0);
         return 1;
      end
      move_column((code - CH_LOWER_A + 2) * 6);
      return 0;
   endfunction

   function automatic string cmd_text(input cmd_type cmd);
      return $sformatf("kind %0d plane %0d row %0d column %0d pattern %0d bits %0d run %0d repeat %0d",
                       cmd.kind, cmd.plane, cmd.row, cmd.column, cmd.pattern,
                       cmd.pattern_bits, cmd.run_length, cmd.repeat_count);
   endfunction

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", what);
   endfunction

   always @(posedge clock) begin : watch
      cmd_type seen;
      cmd_type want;
      if (reset) begin
         cfg_mode      = MODE_RUNS;
         cfg_width     = MAX_DIM;
         cfg_height    = MAX_DIM;
         cfg_depth     = MAX_DIM;
         cfg_threshold = RESET_THRESHOLD;
         ph            = PH_NORMAL;
         col_pos       = 0;
         row_pos       = 0;
         plane_pos     = 0;
         count_acc     = 0;
         predicted_cmds.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_kind, rsp_plane, rsp_row, rsp_column, rsp_pattern,
                     rsp_pattern_bits, rsp_run_length, rsp_repeat_count};
            if (predicted_cmds.size() == 0) begin
               note_failure($sformatf("unexpected command: %s", cmd_text(seen)));
            end else begin
               want = predicted_cmds.pop_front();
               if (seen !== want) begin
                  note_failure($sformatf("command mismatch: expected %s, got %s",
                                         cmd_text(want), cmd_text(seen)));
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_MODE:      cfg_mode = csr_data[1:0];
               CSR_WIDTH:     cfg_width = csr_data;
               CSR_HEIGHT:    cfg_height = csr_data;
               CSR_DEPTH:     cfg_depth = csr_data;
               CSR_THRESHOLD: cfg_threshold = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (decode_char(req_char_code, want)) predicted_cmds.push_back(want);
         end
      end
      outstanding = predicted_cmds.size();
   end

endmodule

// ===== sim/bitmap_row_text_decoder_test.sv =====
// Top of the bitmap row text decoder testbench: clock, reset, stimulus and verdict.
module bitmap_row_text_decoder_test;
   import brtd_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_DEL  = 8'h7f;
   localparam logic [7:0] CH_MSB  = 8'h80;
   localparam logic [7:0] CH_HIGH = 8'hff;
   localparam logic [7:0] CH_TICK = 8'h60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_code;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [9:0]  rsp_plane;
   logic [9:0]  rsp_row;
   logic [9:0]  rsp_column;
   logic [5:0]  rsp_pattern;
   logic [2:0]  rsp_pattern_bits;
   logic [6:0]  rsp_run_length;
   logic [10:0] rsp_repeat_count;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [10:0] csr_data;

   int failures;
   int outstanding;
   int plane_now;

   int send_idle_pct;
   int take_idle_pct;
   int hold_id;
   int hold_seen;
   int hold_left;
   int cycles;
   int chars_sent;
   logic [1:0] cur_mode;

   bitmap_row_text_decoder dut (.*);

   bitmap_row_text_decoder_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls at random, or for a long stretch when a hold-off is requested.
   initial begin
      hold_seen = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_id != hold_seen) begin
            hold_seen = hold_id;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < take_idle_pct);
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_char(input logic [7:0] c);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   // Waits until every predicted command has arrived and the pipeline has emptied.
   task automatic settle;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] m, input int w, input int h, input int d,
                            input int t);
      cur_mode = m;
      csr_write <= 1'b1;
      csr_index <= CSR_MODE;
      csr_data  <= 11'(m);
      @(posedge clock);
      csr_index <= CSR_WIDTH;
      csr_data  <= 11'(w);
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_data  <= 11'(h);
      @(posedge clock);
      csr_index <= CSR_DEPTH;
      csr_data  <= 11'(d);
      @(posedge clock);
      csr_index <= CSR_THRESHOLD;
      csr_data  <= 11'(t);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char;
      int r;
      r = $urandom_range(21);
      if (r < 10) return CH_ZERO + 8'(r);
      if (r < 16) return CH_LOWER_A + 8'(r - 10);
      return 8'd65 + 8'(r - 16);
   endfunction

   // One text line of random content, sometimes with a repeat marker, then usually a line end.
   task automatic send_random_line(input int longest);
      int n;
      int r;
      n = ($urandom_range(99) < 5) ? $urandom_range(60, 20) : $urandom_range(longest);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 4) begin
            send_char(8'($urandom_range(255)));
         end else if (r < 12 && cur_mode == MODE_RUNS) begin
            send_char(CH_BAR);
            repeat ($urandom_range(3)) send_char(CH_ZERO + 8'($urandom_range(9)));
         end else if (r < 70 && cur_mode == MODE_HEX) begin
            send_char(hex_char());
         end else begin
            send_char(8'($urandom_range(127, 32)));
         end
      end
      r = $urandom_range(99);
      if (r < 40) begin
         send_char(CH_LF);
      end else if (r < 70) begin
         send_char(CH_CR);
         send_char(CH_LF);
      end else if (r < 80) begin
         send_char(CH_CR);
      end else if (r < 90) begin
         send_char($urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255, 128)));
      end
   endtask

   task automatic run_phase(input int items, input int longest);
      int stop;
      stop = chars_sent + items;
      while (chars_sent < stop) send_random_line(longest);
   endtask

   initial begin
      hold_id       = 0;
      chars_sent    = 0;
      cur_mode      = MODE_RUNS;
      send_idle_pct = 7;
      take_idle_pct = 48;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_char_code <= 8'd0;
      csr_write     <= 1'b0;
      csr_index     <= CSR_MODE;
      csr_data      <= 11'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings. A repeat on the first row gives no command but still moves rows.
      send_char(CH_BAR);
      send_char(CH_ZERO + 8'd3);
      send_char(CH_LF);
      // Space and backtick give full groups, then off and on runs, then a mid-row repeat
      // closed by a carriage return whose line feed must be swallowed.
      send_char(CH_SPACE);
      send_char(CH_BANG);
      send_char(CH_TICK);
      send_char(CH_LOWER_A);
      send_char(CH_LOWER_N);
      send_char(CH_BAR);
      send_char(CH_CR);
      send_char(CH_LF);
      // Longest runs push the column past the width until it saturates.
      repeat (9) send_char(CH_DEL);
      send_char(CH_BANG);
      send_char(CH_HIGH);
      send_char(CH_NUL);
      send_char(CH_MSB);
      settle();

      configure(MODE_RUNS, 40, 5, 1024, 49);
      run_phase(50, 12);
      // Long receiver hold-off while characters keep coming, so the block backs up.
      hold_id++;
      run_phase(40, 12);
      settle();

      configure(MODE_BIT, 1, 3, 2047, 33);
      run_phase(80, 6);
      settle();

      send_idle_pct = 48;
      take_idle_pct = 7;
      configure(MODE_HEX, 1024, 1024, 1024, 126);
      run_phase(40, 20);
      settle();
      run_phase(40, 20);
      settle();

      configure(2'd3, 7, 0, 1024, 127);
      run_phase(80, 10);
      settle();

      send_idle_pct = 0;
      take_idle_pct = 0;
      configure(MODE_RUNS, 2047, 2, 1100, 90);
      run_phase(90, 25);
      settle();

      configure(MODE_RUNS, 13, 1, 1024, 0);
      run_phase(60, 8);
      settle();

      // Depth is the current plane plus two, so the volume finishes and later bytes are ignored.
      configure(MODE_BIT, 3, 2, (plane_now + 2 > MAX_DIM) ? MAX_DIM : plane_now + 2, 64);
      run_phase(30, 4);
      settle();

      configure(MODE_RUNS, 1024, 1024, 0, 49);
      run_phase(10, 4);
      settle();

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
